FILE: hdl/spq_pkg.sv
`timescale 1ns / 1ps

package spq_pkg;

   localparam int DEPTH = 16;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = $clog2(DEPTH);
   localparam int VAL_W = 32;
   localparam int OCC_W = 5;
   localparam int STATUS_W = 2;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic                    operation;
      logic signed [VAL_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] removed_value;
      logic [STATUS_W-1:0]     status;
      logic [OCC_W-1:0]        occupancy;
   } rsp_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      logic [VAL_W-1:0] data;
   } spq_wr_type;

endpackage

FILE: hdl/spq_store.sv
`timescale 1ns / 1ps

module spq_store
   import spq_pkg::*;
(
   input  logic             clock,
   input  spq_wr_type       wr,
   input  logic [IDX_W-1:0] rd_addr,
   output logic [VAL_W-1:0] rd_data
);

   logic [VAL_W-1:0] mem_ff [DEPTH];
   logic [VAL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/sorted_priority_queue_core.sv
`timescale 1ns / 1ps

// Sorted priority queue of signed 32-bit values, 16 entries, kept in ascending
// order in a single-port-read, single-port-write RAM; equal values leave in
// arrival order. A request is taken when start is high and busy is low. An
// insert keeps busy high while it moves the larger stored entries up one slot
// and writes the new value; a remove keeps busy high while it reads the head
// and shifts the rest down. Both walk the RAM one entry per cycle through its
// registered read port, and inserts use a single signed comparator. A rejected
// request (insert when full, remove when empty) does not raise busy. Every
// request gives exactly one response, shown on rsp_data for one cycle with
// rsp_strobe high, in the cycle after the work ends; the receiver cannot stall
// it and must take it in that cycle. A new request may be issued in the same
// cycle that a response is shown.
module sorted_priority_queue_core
   import spq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   typedef enum logic [2:0] {
      IDLE,
      INS_FETCH,
      INS_CMP,
      INS_PUT,
      REM_HEAD,
      REM_CAP,
      REM_SHIFT
   } state_type;

   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [IDX_W-1:0]        pos_ff, pos_in;
   logic [CNT_W-1:0]        idx_ff, idx_in;
   logic signed [VAL_W-1:0] value_ff, value_in;
   logic signed [VAL_W-1:0] removed_ff, removed_in;
   logic                    rsp_strobe_ff, rsp_strobe_in;
   rsp_type                 rsp_ff, rsp_in;

   spq_wr_type       wr;
   logic [IDX_W-1:0] rd_addr;
   logic [VAL_W-1:0] rd_data;
   logic             ins_done;
   logic             rem_done;
   logic             finish;

   spq_store u_store (
      .clock   (clock),
      .wr      (wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      idx_in        = idx_ff;
      value_in      = value_ff;
      removed_in    = removed_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      wr            = '{en: 1'b0, addr: '0, data: '0};
      rd_addr       = '0;
      ins_done      = 1'b0;
      rem_done      = 1'b0;

      unique case (state_ff)
         IDLE: begin
            if (start) begin
               value_in = req_data.value;
               if (req_data.operation == OP_INSERT) begin
                  if (count_ff == CNT_W'(DEPTH)) begin
                     rsp_strobe_in = 1'b1;
                     rsp_in = '{removed_value: '0, status: STATUS_FULL,
                                occupancy: OCC_W'(count_ff)};
                  end else begin
                     pos_in   = IDX_W'(count_ff);
                     state_in = (count_ff == '0) ? INS_PUT : INS_FETCH;
                  end
               end else begin
                  if (count_ff == '0) begin
                     rsp_strobe_in = 1'b1;
                     rsp_in = '{removed_value: '0, status: STATUS_EMPTY,
                                occupancy: OCC_W'(count_ff)};
                  end else begin
                     idx_in   = CNT_W'(1);
                     state_in = REM_HEAD;
                  end
               end
            end
         end
         INS_FETCH: begin
            rd_addr  = pos_ff - IDX_W'(1);
            state_in = INS_CMP;
         end
         INS_CMP: begin
            if ($signed(rd_data) > value_ff) begin
               // move the larger entry up one slot and look one further down
               wr     = '{en: 1'b1, addr: pos_ff, data: rd_data};
               pos_in = pos_ff - IDX_W'(1);
               if (pos_ff == IDX_W'(1)) begin
                  state_in = INS_PUT;
               end else begin
                  rd_addr = pos_ff - IDX_W'(2);
               end
            end else begin
               wr       = '{en: 1'b1, addr: pos_ff, data: value_ff};
               ins_done = 1'b1;
            end
         end
         INS_PUT: begin
            wr       = '{en: 1'b1, addr: pos_ff, data: value_ff};
            ins_done = 1'b1;
         end
         REM_HEAD: begin
            rd_addr  = '0;
            state_in = REM_CAP;
         end
         REM_CAP: begin
            removed_in = rd_data;
            if (count_ff == CNT_W'(1)) begin
               rem_done = 1'b1;
            end else begin
               rd_addr  = idx_ff[IDX_W-1:0];
               state_in = REM_SHIFT;
            end
         end
         REM_SHIFT: begin
            wr = '{en: 1'b1, addr: IDX_W'(idx_ff - CNT_W'(1)), data: rd_data};
            if ((idx_ff + CNT_W'(1)) < count_ff) begin
               rd_addr = IDX_W'(idx_ff + CNT_W'(1));
               idx_in  = idx_ff + CNT_W'(1);
            end else begin
               rem_done = 1'b1;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase

      if (ins_done) begin
         count_in      = count_ff + CNT_W'(1);
         rsp_strobe_in = 1'b1;
         rsp_in = '{removed_value: '0, status: STATUS_DONE,
                    occupancy: OCC_W'(count_ff + CNT_W'(1))};
         state_in      = IDLE;
      end
      if (rem_done) begin
         count_in      = count_ff - CNT_W'(1);
         rsp_strobe_in = 1'b1;
         rsp_in = '{removed_value: removed_in, status: STATUS_DONE,
                    occupancy: OCC_W'(count_ff - CNT_W'(1))};
         state_in      = IDLE;
      end
   end

   assign finish = ins_done || rem_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= IDLE;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      pos_ff     <= pos_in;
      idx_ff     <= idx_in;
      value_ff   <= value_in;
      removed_ff <= removed_in;
      rsp_ff     <= rsp_in;
   end

   assign busy       = (state_ff != IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   a_rsp_only_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> !busy)
      else $error("response shown while busy");

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("stored count above depth");

   a_full_reject: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.operation == OP_INSERT && count_ff == CNT_W'(DEPTH))
      |=> (rsp_strobe_ff && rsp_ff.status == STATUS_FULL))
      else $error("insert into full queue not rejected");

   a_empty_reject: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.operation == OP_REMOVE && count_ff == '0)
      |=> (rsp_strobe_ff && rsp_ff.status == STATUS_EMPTY))
      else $error("remove from empty queue not rejected");

   a_count_holds: assert property (@(posedge clock) disable iff (reset)
      !finish |=> $stable(count_ff))
      else $error("stored count changed outside completion");

   a_occupancy_match: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> (rsp_ff.occupancy == OCC_W'(count_ff)))
      else $error("response occupancy differs from stored count");

endmodule
